/* rtl/hfl_pkg.sv */
// shared types and constants for the hashed frequency leader
package hfl_pkg;

  localparam int KEY_W = 37;
  localparam int CNT_W = 16;
  localparam int TIE_W = 13;
  localparam int MOD_W = 11;
  localparam int DIV_W = 17;
  localparam int LEN_W = 6;

  // 100000 = 2^5 * 3125: the low five bits pass through, the rest is taken mod 3125
  localparam int LOW_BITS = 5;
  localparam int FOLD_W   = 32;
  localparam int Q_W      = 5;
  localparam int RECIP_SH = 27;

  localparam logic [LEN_W-1:0]  LEN_LOW   = 6'd17;
  localparam logic [FOLD_W-1:0] FOLD_K    = 32'd3036;   // 2^16 mod 3125
  localparam logic [FOLD_W-1:0] RECIP_K   = 32'd42950;  // ceil(2^27 / 3125)
  localparam logic [DIV_W-1:0]  ODD_DIV   = 17'd3125;
  localparam logic [1:0]        FOLD_LAST = 2'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;
  localparam logic [TIE_W-1:0]  TIE_MAX   = 13'h1FFF;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

/* rtl/hashed_frequency_leader_top.sv */
// top level of the hashed frequency leader
// Counts how often each 37-bit number has been seen in a hash table of BUCKETS rows of
// WAYS ways, held in one synchronous memory of one row per bucket (valid, key and count
// for every way). The bucket is (number mod 100000) mod bucket_modulus, where a modulus
// of zero acts as 1 and one above BUCKETS acts as BUCKETS. The first remainder is built
// from the low five bits and the rest of the number taken mod 3125: fold steps
// shrink it below 2^17, a quotient state forms a reciprocal quotient estimate and the
// next state subtracts and starts the bit-serial remainder unit on the 17-bit low digits.
// That unit shifts in the 17 bits and then raises done, which also issues the row read;
// then the update state updates and writes back. The serial remainder by the modulus
// takes up most of the time a word spends. After reset a clearing pass writes empty
// rows, one per cycle, over all BUCKETS rows before the first word is taken;
// configuration writes are taken during it. A finished result waits in the output
// register while the next word is already being worked on. A number that finds its
// bucket full is dropped with bucket_full set and a count of zero; counts saturate at
// 65535 and the tie count at 8191.
module hashed_frequency_leader_top import hfl_pkg::*; #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [MOD_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] phone_number,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CNT_W-1:0] number_count,
  output logic [KEY_W-1:0] leader_number,
  output logic [CNT_W-1:0] leader_count,
  output logic [TIE_W-1:0] tie_count,
  output logic             bucket_full
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [DIV_W-1:0] BUCKETS_D = DIV_W'(BUCKETS);
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_QUOT  = 3'd3;
  localparam logic [2:0] S_MODA  = 3'd4;
  localparam logic [2:0] S_MODB  = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;

  typedef entry_t [WAYS-1:0] row_t;

  logic [2:0]       state;
  logic [MOD_W-1:0] bucket_modulus;
  logic [BW-1:0]    clr_addr;
  logic [KEY_W-1:0] num;
  logic [BW-1:0]    bucket;

  // low-digit reduction
  logic [FOLD_W-1:0] fx;
  logic [FOLD_W-1:0] fold_next;
  logic [1:0]        fold_n;
  logic [FOLD_W-1:0] q_prod;
  logic [Q_W-1:0]    quot;
  logic [DIV_W-1:0]  odd_rem;
  logic [DIV_W-1:0]  low_digits;

  // leader state
  logic [KEY_W-1:0] best_number;
  logic [CNT_W-1:0] best_count;
  logic [TIE_W-1:0] best_ties;

  // table memory
  row_t mem [BUCKETS];
  row_t rd_row;
  logic          mem_we;
  logic [BW-1:0] mem_waddr;
  row_t          mem_wdata;
  logic          mem_re;

  // remainder unit hookup
  logic             rm_start;
  logic [KEY_W-1:0] rm_value;
  logic [LEN_W-1:0] rm_len;
  logic [DIV_W-1:0] rm_div;
  logic             rm_done;
  logic [DIV_W-1:0] rm_rem;
  logic [DIV_W-1:0] eff_mod;

  // update path
  logic          hit;
  logic          has_free;
  logic [WW-1:0] hit_w;
  logic [WW-1:0] free_w;
  logic [CNT_W-1:0] cnt_new;
  logic          note;
  logic          full;
  row_t          row_next;
  logic          commit;

  logic [KEY_W-1:0] best_number_next;
  logic [CNT_W-1:0] best_count_next;
  logic [TIE_W-1:0] best_ties_next;

  hfl_remainder u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rm_start),
    .value   (rm_value),
    .len     (rm_len),
    .divisor (rm_div),
    .done    (rm_done),
    .rem     (rm_rem)
  );

  // modulus clamp: zero acts as one, above the table acts as the table size
  always_comb begin
    eff_mod = {{(DIV_W-MOD_W){1'b0}}, bucket_modulus};
    if (eff_mod == '0) begin
      eff_mod = DIV_W'(1);
    end else if (eff_mod > BUCKETS_D) begin
      eff_mod = BUCKETS_D;
    end
  end

  assign in_stall = (state != S_IDLE);

  // one fold step: 2^16 is 3036 mod 3125, so the high half is folded onto the low half
  assign fold_next = ({16'b0, fx[31:16]} * FOLD_K) + {16'b0, fx[15:0]};

  // after four folds fx is below 86788, where the reciprocal quotient is exact
  assign q_prod     = {{(FOLD_W-DIV_W){1'b0}}, fx[DIV_W-1:0]} * RECIP_K;
  assign odd_rem    = fx[DIV_W-1:0] - ({{(DIV_W-Q_W){1'b0}}, quot} * ODD_DIV);
  assign low_digits = {odd_rem[DIV_W-LOW_BITS-1:0], num[LOW_BITS-1:0]};

  // remainder unit: low digits left-aligned, divided by the clamped modulus
  assign rm_start = (state == S_MODA);
  assign rm_value = {low_digits, {(KEY_W-DIV_W){1'b0}}};
  assign rm_len   = LEN_LOW;
  assign rm_div   = eff_mod;

  // way search over the registered row
  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_w    = '0;
    free_w   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row[w].valid) begin
        if (!hit && rd_row[w].key == num) begin
          hit   = 1'b1;
          hit_w = WW'(w);
        end
      end else if (!has_free) begin
        has_free = 1'b1;
        free_w   = WW'(w);
      end
    end
  end

  always_comb begin
    row_next = rd_row;
    cnt_new  = '0;
    note     = 1'b0;
    full     = 1'b0;
    if (hit) begin
      cnt_new = rd_row[hit_w].cnt;
      if (rd_row[hit_w].cnt != CNT_MAX) begin
        cnt_new = rd_row[hit_w].cnt + 1'b1;
        row_next[hit_w].cnt = cnt_new;
        note = 1'b1;
      end
    end else if (has_free) begin
      cnt_new = CNT_W'(1);
      row_next[free_w].valid = 1'b1;
      row_next[free_w].key   = num;
      row_next[free_w].cnt   = cnt_new;
      note = 1'b1;
    end else begin
      full = 1'b1;
    end
  end

  // running leader: smallest number at the highest count
  always_comb begin
    best_number_next = best_number;
    best_count_next  = best_count;
    best_ties_next   = best_ties;
    if (note) begin
      if (cnt_new > best_count) begin
        best_count_next  = cnt_new;
        best_number_next = num;
        best_ties_next   = TIE_W'(1);
      end else if (cnt_new == best_count) begin
        if (best_ties != TIE_MAX) begin
          best_ties_next = best_ties + 1'b1;
        end
        if (num < best_number) begin
          best_number_next = num;
        end
      end
    end
  end

  // the update finishes once the output register is free
  assign commit = (state == S_UPD) && (!out_valid || !out_stall);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bucket;
    mem_wdata = row_next;
    mem_re    = (state == S_MODB) && rm_done;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (commit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row <= mem[rm_rem[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      bucket_modulus <= MOD_W'(1024);
      best_number    <= '0;
      best_count     <= '0;
      best_ties      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        bucket_modulus <= cfg_data;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ROW) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (fold_n == FOLD_LAST) begin
            state <= S_QUOT;
          end
        end
        S_QUOT: begin
          state <= S_MODA;
        end
        S_MODA: begin
          state <= S_MODB;
        end
        S_MODB: begin
          if (rm_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (commit) begin
            state       <= S_IDLE;
            best_number <= best_number_next;
            best_count  <= best_count_next;
            best_ties   <= best_ties_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      num    <= phone_number;
      fx     <= phone_number[KEY_W-1:LOW_BITS];
      fold_n <= '0;
    end
    if (state == S_FOLD) begin
      fx     <= fold_next;
      fold_n <= fold_n + 1'b1;
    end
    if (state == S_QUOT) begin
      quot <= q_prod[RECIP_SH+Q_W-1:RECIP_SH];
    end
    if (mem_re) begin
      bucket <= rm_rem[BW-1:0];
    end
    if (commit) begin
      number_count  <= cnt_new;
      leader_number <= best_number_next;
      leader_count  <= best_count_next;
      tie_count     <= best_ties_next;
      bucket_full   <= full;
    end
  end

endmodule

/* rtl/hfl_remainder.sv */
// bit-serial remainder unit, one dividend bit per cycle
module hfl_remainder import hfl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] value,
  input  logic [LEN_W-1:0] len,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] rem
);

  logic             busy;
  logic [LEN_W-1:0] cnt;
  logic [KEY_W-1:0] sh;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W-1:0] r;
  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] r_next;

  assign done = busy && (cnt == '0);
  assign rem  = r;

  always_comb begin
    trial = {r, sh[KEY_W-1]};
    if (trial >= {1'b0, dvs}) begin
      r_next = DIV_W'(trial - {1'b0, dvs});
    end else begin
      r_next = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= len;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= value;
      dvs <= divisor;
      r   <= '0;
    end else if (busy && (cnt != '0)) begin
      sh <= {sh[KEY_W-2:0], 1'b0};
      r  <= r_next;
    end
  end

endmodule
